@@ hw/rtl/ccint_pkg.sv @@
`default_nettype none

package ccint_pkg;

  localparam int CCINT_COORD_WIDTH = 32;
  localparam int CCINT_EPS_WIDTH   = 16;
  localparam logic [CCINT_EPS_WIDTH-1:0] CCINT_EPS_RESET = 16'd66;

  typedef enum logic [1:0] {
    CNT_NONE  = 2'd0,
    CNT_ONE   = 2'd1,
    CNT_TWO   = 2'd2,
    CNT_COINC = 2'd3
  } ccint_count_t;

endpackage

`default_nettype wire

@@ hw/rtl/ccint_if.sv @@
`default_nettype none

interface ccint_in_if import ccint_pkg::*; #(
  parameter int W = CCINT_COORD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] first_center_x;
  logic [W-1:0] first_center_y;
  logic [W-1:0] second_center_x;
  logic [W-1:0] second_center_y;
  logic [W-2:0] first_radius;
  logic [W-2:0] second_radius;

  modport source (output valid, first_center_x, first_center_y, second_center_x,
                  second_center_y, first_radius, second_radius, input ready);
  modport sink (input valid, first_center_x, first_center_y, second_center_x,
                second_center_y, first_radius, second_radius, output ready);
endinterface

interface ccint_out_if import ccint_pkg::*; #(
  parameter int W = CCINT_COORD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [1:0]   point_count;
  logic [W-1:0] point_a_x;
  logic [W-1:0] point_a_y;
  logic [W-1:0] point_b_x;
  logic [W-1:0] point_b_y;

  modport source (output valid, point_count, point_a_x, point_a_y, point_b_x, point_b_y,
                  input ready);
  modport sink (input valid, point_count, point_a_x, point_a_y, point_b_x, point_b_y,
                output ready);
endinterface

interface ccint_cfg_if import ccint_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CCINT_EPS_WIDTH-1:0] eps_len;

  modport source (output valid, eps_len, input ready);
  modport sink (input valid, eps_len, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ccint_sqrt.sv @@
`default_nettype none

// Pipelined restoring square root, one result bit per stage, rounded to nearest.
module ccint_sqrt #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [IN_W-1:0]     rad,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [IN_W/2-1:0]        root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int OW = IN_W / 2;

  logic              st_v    [OW];
  logic [OW+1:0]     st_rem  [OW];
  logic [OW-1:0]     st_root [OW];
  logic [IN_W-1:0]   st_rad  [OW];
  logic [SIDE_W-1:0] st_side [OW];

  logic [OW+1:0]     c_rem   [OW];
  logic [OW-1:0]     c_root  [OW];
  logic [IN_W-1:0]   c_rad   [OW];
  logic [OW+1:0]     acc     [OW];
  logic [OW+1:0]     trial   [OW];
  logic [OW+1:0]     n_rem   [OW];
  logic [OW-1:0]     n_root  [OW];
  logic              rnd;

  always_comb begin
    c_rem[0]  = '0;
    c_root[0] = '0;
    c_rad[0]  = rad;
    for (int i = 1; i < OW; i++) begin
      c_rem[i]  = st_rem[i-1];
      c_root[i] = st_root[i-1];
      c_rad[i]  = st_rad[i-1];
    end
    for (int i = 0; i < OW; i++) begin
      // remainder stays below 2^OW until the last step
      acc[i]   = {c_rem[i][OW-1:0], c_rad[i][IN_W-1 -: 2]};
      trial[i] = {c_root[i], 2'b01};
      if (acc[i] >= trial[i]) begin
        n_rem[i]  = acc[i] - trial[i];
        n_root[i] = {c_root[i][OW-2:0], 1'b1};
      end else begin
        n_rem[i]  = acc[i];
        n_root[i] = {c_root[i][OW-2:0], 1'b0};
      end
    end
  end

  assign rnd = st_rem[OW-1] > (OW+2)'(st_root[OW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OW; i++) st_v[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int i = 1; i < OW; i++) st_v[i] <= st_v[i-1];
      out_valid <= st_v[OW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < OW; i++) begin
        st_rem[i]  <= n_rem[i];
        st_root[i] <= n_root[i];
        st_rad[i]  <= c_rad[i] << 2;
      end
      st_side[0] <= in_side;
      for (int i = 1; i < OW; i++) st_side[i] <= st_side[i-1];
      root     <= st_root[OW-1] + OW'(rnd);
      out_side <= st_side[OW-1];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ccint_div.sv @@
`default_nettype none

// Pipelined restoring divider, rounded to nearest (half the divisor added first).
// One quotient bit per stage; ovf flags a quotient that needs more than QW bits.
// Needs NW + 1 - QW >= DW.
module ccint_div #(
  parameter int NW     = 64,
  parameter int DW     = 33,
  parameter int QW     = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NW-1:0]     num,
  input  wire logic [DW-1:0]     den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [QW-1:0]          quo,
  output logic                   ovf,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int HW = NW + 1 - QW;

  logic [NW:0]       biased;
  logic              st_v    [QW+1];
  logic [DW-1:0]     st_rem  [QW+1];
  logic [QW-1:0]     st_lo   [QW+1];
  logic [DW-1:0]     st_den  [QW+1];
  logic              st_ovf  [QW+1];
  logic [SIDE_W-1:0] st_side [QW+1];
  logic [DW:0]       acc     [QW+1];
  logic              ge      [QW+1];

  assign biased = (NW+1)'(num) + (NW+1)'(den >> 1);

  always_comb begin
    acc[0] = '0;
    ge[0]  = 1'b0;
    for (int i = 1; i <= QW; i++) begin
      acc[i] = {st_rem[i-1], st_lo[i-1][QW-1]};
      ge[i]  = acc[i] >= (DW+1)'(st_den[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QW; i++) st_v[i] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int i = 1; i <= QW; i++) st_v[i] <= st_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0]  <= biased[QW +: DW];
      st_lo[0]   <= biased[QW-1:0];
      st_den[0]  <= den;
      st_ovf[0]  <= biased[NW:QW] >= HW'(den);
      st_side[0] <= in_side;
      for (int i = 1; i <= QW; i++) begin
        st_rem[i]  <= ge[i] ? DW'(acc[i] - (DW+1)'(st_den[i-1])) : acc[i][DW-1:0];
        st_lo[i]   <= {st_lo[i-1][QW-2:0], ge[i]};
        st_den[i]  <= st_den[i-1];
        st_ovf[i]  <= st_ovf[i-1];
        st_side[i] <= st_side[i-1];
      end
    end
  end

  assign out_valid = st_v[QW];
  assign quo       = st_lo[QW];
  assign ovf       = st_ovf[QW];
  assign out_side  = st_side[QW];

endmodule

`default_nettype wire

@@ hw/rtl/circle_circle_intersection.sv @@
// Circle-circle intersection on signed fixed-point coordinates (radii unsigned, one bit
// narrower). The larger circle is taken as circle 0; the center distance, the chord
// offset a and half-chord h come from exact integer math with round-to-nearest square
// roots and divisions, and all case tests use the eps_len tolerance (raw LSBs, reset 66).
// point_count: 0 none, 1 tangent or single point, 2 crossing, 3 coincident; unused points
// read zero and coordinates saturate. One item per clock unless stalled. Back-pressure
// stalls the whole pipeline only when the output register is full and not being read and
// the last stage holds an item. eps_len may be written while idle.
`default_nettype none

module circle_circle_intersection import ccint_pkg::*; #(
  parameter int COORD_WIDTH = CCINT_COORD_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst,
  ccint_in_if.sink  req,
  ccint_out_if.source rsp,
  ccint_cfg_if.sink cfg
);

  localparam int W    = COORD_WIDTH;
  localparam int RW   = W - 1;
  localparam int D2W  = 2 * W + 2;
  localparam int DLW  = W + 1;
  localparam int NUMW = 2 * W + 2;
  localparam int DENW = W + 2;
  localparam int RSQ  = 2 * RW;
  localparam int PW   = RW + W;
  localparam int SW   = PW + 2;
  localparam int MAGW = 2 * W;
  localparam int CW   = W + CCINT_EPS_WIDTH;

  typedef struct packed {
    logic [W-1:0]   x0, y0;
    logic [RW-1:0]  r0, r1;
    logic           dxn, dyn;
    logic [W-1:0]   dxm, dym;
    logic [RSQ-1:0] rr;
    logic [D2W-1:0] d2;
  } sq1_side_t;

  typedef struct packed {
    logic [W-1:0]  x0, y0;
    logic [RW-1:0] r0;
    logic          dxn, dyn;
    logic [W-1:0]  dxm, dym;
    logic [DLW-1:0] d;
    ccint_count_t  cnt;
    logic          tan, pc0;
  } dv1_side_t;

  typedef struct packed {
    logic [W-1:0]   x0, y0;
    logic [RW-1:0]  a;
    logic           dxn, dyn;
    logic [W-1:0]   dxm, dym;
    logic [DLW-1:0] d;
    ccint_count_t   cnt;
    logic           pc0;
  } sq2_side_t;

  typedef struct packed {
    logic [W-1:0] x0, y0;
    ccint_count_t cnt;
    logic         pc0;
    logic         neg;
  } dvp_side_t;

  function automatic logic [SW-1:0] sterm(input logic [PW-1:0] m, input logic ng);
    logic [SW-1:0] e;
    e = SW'(m);
    return ng ? (~e + SW'(1)) : e;
  endfunction

  function automatic logic [W-1:0] fin(input logic [W-1:0] x0, input logic [W-1:0] q,
                                       input logic ov, input logic ng);
    logic [W+1:0] ext, qq, v, hi, lo;
    ext = {{2{x0[W-1]}}, x0};
    qq  = (W+2)'(ov ? {W{1'b1}} : q);
    v   = ng ? ext - qq : ext + qq;
    hi  = {3'b000, {(W-1){1'b1}}};
    lo  = {3'b111, {(W-1){1'b0}}};
    if ($signed(v) > $signed(hi)) return hi[W-1:0];
    if ($signed(v) < $signed(lo)) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  logic [CCINT_EPS_WIDTH-1:0] eps_len;
  logic en, lastv, outv;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) eps_len <= CCINT_EPS_RESET;
    else if (cfg.valid) eps_len <= cfg.eps_len;
  end

  // stage 1: order circles
  logic          s1_v, swap;
  logic [W-1:0]  s1_x0, s1_y0, s1_x1, s1_y1;
  logic [RW-1:0] s1_r0, s1_r1;
  assign swap = req.second_radius > req.first_radius;

  // stage 2: center difference as sign and magnitude
  logic          s2_v, s2_dxn, s2_dyn;
  logic [W-1:0]  s2_x0, s2_y0, s2_dxm, s2_dym;
  logic [RW-1:0] s2_r0, s2_r1;
  logic [W:0]    dx, dy, ndx, ndy;
  assign dx  = {s1_x1[W-1], s1_x1} - {s1_x0[W-1], s1_x0};
  assign dy  = {s1_y1[W-1], s1_y1} - {s1_y0[W-1], s1_y0};
  assign ndx = -dx;
  assign ndy = -dy;

  // stage 3: squares
  logic           s3_v, s3_dxn, s3_dyn;
  logic [W-1:0]   s3_x0, s3_y0, s3_dxm, s3_dym;
  logic [RW-1:0]  s3_r0, s3_r1;
  logic [2*W-1:0] s3_dx2, s3_dy2;
  logic [RSQ-1:0] s3_r0sq, s3_r1sq;

  // stage 4: squared distance
  logic      s4_v;
  sq1_side_t s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s1_v <= req.valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x0 <= swap ? req.second_center_x : req.first_center_x;
      s1_y0 <= swap ? req.second_center_y : req.first_center_y;
      s1_x1 <= swap ? req.first_center_x : req.second_center_x;
      s1_y1 <= swap ? req.first_center_y : req.second_center_y;
      s1_r0 <= swap ? req.second_radius : req.first_radius;
      s1_r1 <= swap ? req.first_radius : req.second_radius;

      s2_x0  <= s1_x0;
      s2_y0  <= s1_y0;
      s2_r0  <= s1_r0;
      s2_r1  <= s1_r1;
      s2_dxn <= dx[W];
      s2_dyn <= dy[W];
      s2_dxm <= dx[W] ? ndx[W-1:0] : dx[W-1:0];
      s2_dym <= dy[W] ? ndy[W-1:0] : dy[W-1:0];

      s3_x0   <= s2_x0;
      s3_y0   <= s2_y0;
      s3_r0   <= s2_r0;
      s3_r1   <= s2_r1;
      s3_dxn  <= s2_dxn;
      s3_dyn  <= s2_dyn;
      s3_dxm  <= s2_dxm;
      s3_dym  <= s2_dym;
      s3_dx2  <= (2*W)'(s2_dxm) * (2*W)'(s2_dxm);
      s3_dy2  <= (2*W)'(s2_dym) * (2*W)'(s2_dym);
      s3_r0sq <= RSQ'(s2_r0) * RSQ'(s2_r0);
      s3_r1sq <= RSQ'(s2_r1) * RSQ'(s2_r1);

      s4.x0  <= s3_x0;
      s4.y0  <= s3_y0;
      s4.r0  <= s3_r0;
      s4.r1  <= s3_r1;
      s4.dxn <= s3_dxn;
      s4.dyn <= s3_dyn;
      s4.dxm <= s3_dxm;
      s4.dym <= s3_dym;
      s4.rr  <= s3_r0sq - s3_r1sq;
      s4.d2  <= D2W'(s3_dx2) + D2W'(s3_dy2);
    end
  end

  // center distance
  logic           q1_v;
  logic [DLW-1:0] d1;
  sq1_side_t      q1;

  ccint_sqrt #(.IN_W(D2W), .SIDE_W($bits(sq1_side_t))) u_sqrt_dist (
    .clk, .rst, .en,
    .in_valid (s4_v),
    .rad      (s4.d2),
    .in_side  (s4),
    .out_valid(q1_v),
    .root     (d1),
    .out_side (q1)
  );

  // stage A: chord numerator, distance offsets, same-center tests
  logic            sa_v, sa_same, sa_rok, sa_r0s;
  logic [NUMW-1:0] sa_num;
  logic [DENW-1:0] sa_den;
  logic [DLW-1:0]  sa_e;
  dv1_side_t       sa;
  logic [RW-1:0]   sa_r1;

  // stage B: case decision
  logic            sb_v;
  logic [NUMW-1:0] sb_num;
  logic [DENW-1:0] sb_den;
  dv1_side_t       sb, sb_next;
  logic [DLW-1:0]  g;
  logic            over, gok, b_tan, b_pc0;
  ccint_count_t    b_cnt;

  assign over = CW'(sa_e) > CW'(sa_r1) + CW'(eps_len);
  assign g    = (sa_e > DLW'(sa_r1)) ? sa_e - DLW'(sa_r1) : DLW'(sa_r1) - sa_e;
  assign gok  = CW'(g) <= CW'(eps_len);

  always_comb begin
    b_cnt = CNT_NONE;
    b_tan = 1'b0;
    b_pc0 = 1'b0;
    if (sa_same) begin
      if (sa_rok) begin
        b_cnt = sa_r0s ? CNT_ONE : CNT_COINC;
        b_pc0 = sa_r0s;
      end
    end else if (over) begin
      b_cnt = CNT_NONE;
    end else if (gok) begin
      b_cnt = CNT_ONE;
      b_tan = 1'b1;
    end else begin
      b_cnt = CNT_TWO;
    end
  end

  always_comb begin
    sb_next     = sa;
    sb_next.cnt = b_cnt;
    sb_next.tan = b_tan;
    sb_next.pc0 = b_pc0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= 1'b0;
      sb_v <= 1'b0;
    end else if (en) begin
      sa_v <= q1_v;
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_num  <= NUMW'(q1.rr) + q1.d2;
      sa_den  <= {d1, 1'b0};
      sa_e    <= (d1 > DLW'(q1.r0)) ? d1 - DLW'(q1.r0) : DLW'(q1.r0) - d1;
      sa_same <= CW'(d1) <= CW'(eps_len);
      sa_rok  <= CW'(q1.r0 - q1.r1) <= CW'(eps_len);
      sa_r0s  <= CW'(q1.r0) <= CW'(eps_len);
      sa_r1   <= q1.r1;
      sa.x0   <= q1.x0;
      sa.y0   <= q1.y0;
      sa.r0   <= q1.r0;
      sa.dxn  <= q1.dxn;
      sa.dyn  <= q1.dyn;
      sa.dxm  <= q1.dxm;
      sa.dym  <= q1.dym;
      sa.d    <= d1;
      sa.cnt  <= CNT_NONE;
      sa.tan  <= 1'b0;
      sa.pc0  <= 1'b0;

      sb_num <= sa_num;
      sb_den <= sa_den;
      sb     <= sb_next;
    end
  end

  // chord offset a = (r0^2 + d^2 - r1^2) / 2d
  logic          v1_v, v1_ovf;
  logic [RW-1:0] v1_q;
  dv1_side_t     v1;

  ccint_div #(.NW(NUMW), .DW(DENW), .QW(RW), .SIDE_W($bits(dv1_side_t))) u_div_chord (
    .clk, .rst, .en,
    .in_valid (sb_v),
    .num      (sb_num),
    .den      (sb_den),
    .in_side  (sb),
    .out_valid(v1_v),
    .quo      (v1_q),
    .ovf      (v1_ovf),
    .out_side (v1)
  );

  // stages C, D, E: clamp a (tangent takes a = r0, so h = 0), then r0^2 - a^2
  logic           sc_v, sd_v, se_v;
  sq2_side_t      sc, sd, se;
  logic [RSQ-1:0] sd_asq, sd_r0sq, se_hrad;
  logic [RW-1:0]  sc_r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
      sd_v <= 1'b0;
      se_v <= 1'b0;
    end else if (en) begin
      sc_v <= v1_v;
      sd_v <= sc_v;
      se_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.x0  <= v1.x0;
      sc.y0  <= v1.y0;
      sc.a   <= (v1.tan || v1_ovf || v1_q > v1.r0) ? v1.r0 : v1_q;
      sc.dxn <= v1.dxn;
      sc.dyn <= v1.dyn;
      sc.dxm <= v1.dxm;
      sc.dym <= v1.dym;
      sc.d   <= v1.d;
      sc.cnt <= v1.cnt;
      sc.pc0 <= v1.pc0;
      sc_r0  <= v1.r0;

      sd      <= sc;
      sd_asq  <= RSQ'(sc.a) * RSQ'(sc.a);
      sd_r0sq <= RSQ'(sc_r0) * RSQ'(sc_r0);

      se      <= sd;
      se_hrad <= sd_r0sq - sd_asq;
    end
  end

  // half chord h
  logic          q2_v;
  logic [RW-1:0] h2;
  sq2_side_t     q2;

  ccint_sqrt #(.IN_W(RSQ), .SIDE_W($bits(sq2_side_t))) u_sqrt_chord (
    .clk, .rst, .en,
    .in_valid (se_v),
    .rad      (se_hrad),
    .in_side  (se),
    .out_valid(q2_v),
    .root     (h2),
    .out_side (q2)
  );

  // stages F, G, H: rotated-vector numerators as sign and magnitude
  logic           sf_v, sg_v, sh_v;
  logic [PW-1:0]  sf_pax, sf_pay, sf_phx, sf_phy;
  sq2_side_t      sf, sg, sh;
  logic [SW-1:0]  sg_ax, sg_ay, sg_bx, sg_by;
  logic [SW-1:0]  nax, nay, nbx, nby;
  logic [MAGW-1:0] sh_max, sh_may, sh_mbx, sh_mby;
  logic           sh_nax, sh_nay, sh_nbx, sh_nby;

  assign nax = -sg_ax;
  assign nay = -sg_ay;
  assign nbx = -sg_bx;
  assign nby = -sg_by;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_v <= 1'b0;
      sg_v <= 1'b0;
      sh_v <= 1'b0;
    end else if (en) begin
      sf_v <= q2_v;
      sg_v <= sf_v;
      sh_v <= sg_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf     <= q2;
      sf_pax <= PW'(q2.a) * PW'(q2.dxm);
      sf_pay <= PW'(q2.a) * PW'(q2.dym);
      sf_phx <= PW'(h2) * PW'(q2.dxm);
      sf_phy <= PW'(h2) * PW'(q2.dym);

      sg    <= sf;
      sg_ax <= sterm(sf_pax, sf.dxn) + sterm(sf_phy, sf.dyn);
      sg_ay <= sterm(sf_pay, sf.dyn) + sterm(sf_phx, !sf.dxn);
      sg_bx <= sterm(sf_pax, sf.dxn) + sterm(sf_phy, !sf.dyn);
      sg_by <= sterm(sf_pay, sf.dyn) + sterm(sf_phx, sf.dxn);

      sh     <= sg;
      sh_nax <= sg_ax[SW-1];
      sh_nay <= sg_ay[SW-1];
      sh_nbx <= sg_bx[SW-1];
      sh_nby <= sg_by[SW-1];
      sh_max <= sg_ax[SW-1] ? nax[MAGW-1:0] : sg_ax[MAGW-1:0];
      sh_may <= sg_ay[SW-1] ? nay[MAGW-1:0] : sg_ay[MAGW-1:0];
      sh_mbx <= sg_bx[SW-1] ? nbx[MAGW-1:0] : sg_bx[MAGW-1:0];
      sh_mby <= sg_by[SW-1] ? nby[MAGW-1:0] : sg_by[MAGW-1:0];
    end
  end

  // four coordinate divisions by d
  dvp_side_t    hside, pside;
  logic         pv0, pv1, pv2, pv3;
  logic [W-1:0] qax, qay, qbx, qby;
  logic         oax, oay, obx, oby;
  logic         nay_o, nbx_o, nby_o;

  always_comb begin
    hside.x0  = sh.x0;
    hside.y0  = sh.y0;
    hside.cnt = sh.cnt;
    hside.pc0 = sh.pc0;
    hside.neg = sh_nax;
  end

  ccint_div #(.NW(MAGW), .DW(DLW), .QW(W), .SIDE_W($bits(dvp_side_t))) u_div_ax (
    .clk, .rst, .en, .in_valid(sh_v), .num(sh_max), .den(sh.d), .in_side(hside),
    .out_valid(pv0), .quo(qax), .ovf(oax), .out_side(pside)
  );
  ccint_div #(.NW(MAGW), .DW(DLW), .QW(W), .SIDE_W(1)) u_div_ay (
    .clk, .rst, .en, .in_valid(sh_v), .num(sh_may), .den(sh.d), .in_side(sh_nay),
    .out_valid(pv1), .quo(qay), .ovf(oay), .out_side(nay_o)
  );
  ccint_div #(.NW(MAGW), .DW(DLW), .QW(W), .SIDE_W(1)) u_div_bx (
    .clk, .rst, .en, .in_valid(sh_v), .num(sh_mbx), .den(sh.d), .in_side(sh_nbx),
    .out_valid(pv2), .quo(qbx), .ovf(obx), .out_side(nbx_o)
  );
  ccint_div #(.NW(MAGW), .DW(DLW), .QW(W), .SIDE_W(1)) u_div_by (
    .clk, .rst, .en, .in_valid(sh_v), .num(sh_mby), .den(sh.d), .in_side(sh_nby),
    .out_valid(pv3), .quo(qby), .ovf(oby), .out_side(nby_o)
  );

  // final stage: offset from c0, saturate, blank unused points
  logic [W-1:0] f_ax, f_ay, f_bx, f_by;
  logic [W-1:0] o_ax, o_ay, o_bx, o_by;

  assign f_ax = fin(pside.x0, qax, oax, pside.neg);
  assign f_ay = fin(pside.y0, qay, oay, nay_o);
  assign f_bx = fin(pside.x0, qbx, obx, nbx_o);
  assign f_by = fin(pside.y0, qby, oby, nby_o);

  always_comb begin
    o_ax = '0;
    o_ay = '0;
    o_bx = '0;
    o_by = '0;
    case (pside.cnt)
      CNT_ONE: begin
        o_ax = pside.pc0 ? pside.x0 : f_ax;
        o_ay = pside.pc0 ? pside.y0 : f_ay;
      end
      CNT_TWO: begin
        o_ax = f_ax;
        o_ay = f_ay;
        o_bx = f_bx;
        o_by = f_by;
      end
      default: begin
        o_ax = '0;
      end
    endcase
  end

  assign lastv     = pv0 & pv1 & pv2 & pv3;
  assign en        = !(outv && !rsp.ready && lastv);
  assign req.ready = en;
  assign rsp.valid = outv;

  always_ff @(posedge clk) begin
    if (rst) outv <= 1'b0;
    else if (!outv || rsp.ready) outv <= lastv;
  end

  always_ff @(posedge clk) begin
    if (!outv || rsp.ready) begin
      rsp.point_count <= pside.cnt;
      rsp.point_a_x   <= o_ax;
      rsp.point_a_y   <= o_ay;
      rsp.point_b_x   <= o_bx;
      rsp.point_b_y   <= o_by;
    end
  end

  // input is refused only while a finished item is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready))
    else $error("input stalled without output back-pressure");

  // no point, or coincident circles, carry no coordinates
  a_blank_points: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.point_count == CNT_NONE || rsp.point_count == CNT_COINC)) |->
    (rsp.point_a_x == '0 && rsp.point_a_y == '0 &&
     rsp.point_b_x == '0 && rsp.point_b_y == '0))
    else $error("unused point not zero");

  // a single point never fills point b
  a_single_point: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.point_count == CNT_ONE) |->
    (rsp.point_b_x == '0 && rsp.point_b_y == '0))
    else $error("point b set for a single point");

  // the parallel coordinate dividers stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (pv0 == pv1) && (pv0 == pv2) && (pv0 == pv3))
    else $error("coordinate dividers out of step");

endmodule

`default_nettype wire
